[rtl/zcpf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// zcpf_pkg
// Shared widths, default parameter values and sequencer states for the
// zero-crossing period finder.
// ----------------------------------------------------------------------------
package zcpf_pkg;

    // Fixed port widths
    localparam int SAMPLE_W = 16;
    localparam int PERIOD_W = 32;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF  = 16;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } zcpf_state_t;

endpackage : zcpf_pkg
`default_nettype wire

[rtl/zero_crossing_period_finder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// zero_crossing_period_finder_core
// Upward zero-crossing period finder with linearly interpolated crossings.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_sample take one signed sample per transaction.
//   m_valid/m_ready/m_period/m_saturated return the time between two upward
//   crossings in unsigned fixed point with FRAC_BITS fractional bits.
//   A sample that does not complete an upward crossing leaves the block idle,
//   and it is ready again on the next cycle. A crossing sample runs the
//   crossing fraction through a restoring divider in ST_DIV, one quotient
//   bit per step, then ST_DONE forms the period. No new sample is taken
//   until the sequencer is back in ST_IDLE.
//   The first crossing after reset only sets the reference and gives no
//   result. A count overflow yields period all ones with m_saturated set.
//   The output register holds a finished result while the receiver stalls;
//   new samples are still taken meanwhile, but the next crossing waits in
//   its final cycle until the held result is taken.
//   aresetn is synchronous, active low, and clears all tracking state.
// ----------------------------------------------------------------------------
module zero_crossing_period_finder_core
    import zcpf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic             [PERIOD_W-1:0] m_period,
    output logic                            m_saturated
);

    localparam int ITER_W = $clog2(FRAC_BITS);
    localparam int DIV_W  = SAMPLE_BITS + 1;
    localparam int TW     = COUNT_BITS + FRAC_BITS + 2;
    localparam int EXT_W  = (TW > PERIOD_W + 1) ? TW : PERIOD_W + 1;

    zcpf_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                   have_prev_reg, have_prev_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [FRAC_BITS-1:0]   last_frac_reg, last_frac_next;
    logic                   have_ref_reg, have_ref_next;
    logic                   ovf_reg, ovf_next;

    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       den_reg, den_next;
    logic [FRAC_BITS-1:0]   quo_reg, quo_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;

    logic                   m_valid_reg, m_valid_next;
    logic [PERIOD_W-1:0]    m_period_reg, m_period_next;
    logic                   m_saturated_reg, m_saturated_next;

    logic [SAMPLE_BITS-1:0] cur;
    logic                   crossing;
    logic [SAMPLE_BITS-1:0] mag;
    logic [DIV_W-1:0]       rem_shift;
    logic [EXT_W-1:0]       t_ext;
    logic                   out_free;

    // Bring the port sample to the working width
    generate
        if (SAMPLE_BITS <= SAMPLE_W) begin : g_trunc
            assign cur = s_sample[SAMPLE_BITS-1:0];
        end else begin : g_zext
            assign cur = {{(SAMPLE_BITS - SAMPLE_W){1'b0}}, s_sample};
        end
    endgenerate

    // Previous below zero, current above zero
    assign crossing = have_prev_reg && prev_reg[SAMPLE_BITS-1]
                      && !cur[SAMPLE_BITS-1] && (cur != '0);
    assign mag      = -prev_reg;

    // Shared divider step and period sum
    assign rem_shift = {rem_reg[DIV_W-2:0], 1'b0};
    assign t_ext     = ({{(EXT_W - COUNT_BITS){1'b0}}, count_reg} << FRAC_BITS)
                       + {{(EXT_W - FRAC_BITS){1'b0}}, quo_reg}
                       - {{(EXT_W - FRAC_BITS){1'b0}}, last_frac_reg};
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_period    = m_period_reg;
    assign m_saturated = m_saturated_reg;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            last_frac_reg <= '0;
            have_ref_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            count_reg     <= count_next;
            last_frac_reg <= last_frac_next;
            have_ref_reg  <= have_ref_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rem_reg         <= rem_next;
        den_reg         <= den_next;
        quo_reg         <= quo_next;
        iter_reg        <= iter_next;
        m_period_reg    <= m_period_next;
        m_saturated_reg <= m_saturated_next;
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        prev_next        = prev_reg;
        have_prev_next   = have_prev_reg;
        count_next       = count_reg;
        last_frac_next   = last_frac_reg;
        have_ref_next    = have_ref_reg;
        ovf_next         = ovf_reg;
        rem_next         = rem_reg;
        den_next         = den_reg;
        quo_next         = quo_reg;
        iter_next        = iter_reg;
        m_valid_next     = m_valid_reg;
        m_period_next    = m_period_reg;
        m_saturated_next = m_saturated_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    prev_next      = cur;
                    have_prev_next = 1'b1;
                    if (crossing) begin
                        // Start fraction = mag / (cur + mag)
                        rem_next   = {1'b0, mag};
                        den_next   = {1'b0, cur} + {1'b0, mag};
                        quo_next   = '0;
                        iter_next  = ITER_W'(FRAC_BITS - 1);
                        state_next = ST_DIV;
                    end else if (have_prev_reg) begin
                        if (count_reg == '1) begin
                            ovf_next = 1'b1;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle
                if (rem_shift >= den_reg) begin
                    rem_next = rem_shift - den_reg;
                    quo_next = {quo_reg[FRAC_BITS-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift;
                    quo_next = {quo_reg[FRAC_BITS-2:0], 1'b0};
                end
                if (iter_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (!have_ref_reg || out_free) begin
                    if (have_ref_reg) begin
                        m_valid_next = 1'b1;
                        priority if (ovf_reg) begin
                            m_period_next    = '1;
                            m_saturated_next = 1'b1;
                        end else if (t_ext[EXT_W-1]) begin
                            m_period_next    = '0;
                            m_saturated_next = 1'b0;
                        end else if (t_ext[EXT_W-2:PERIOD_W] != '0) begin
                            m_period_next    = '1;
                            m_saturated_next = 1'b1;
                        end else begin
                            m_period_next    = t_ext[PERIOD_W-1:0];
                            m_saturated_next = 1'b0;
                        end
                    end
                    have_ref_next  = 1'b1;
                    last_frac_next = quo_reg;
                    count_next     = COUNT_BITS'(1);
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    a_noncross_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !crossing) |=> (state_reg == ST_IDLE))
        else $error("non-crossing sample left the idle state");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the final step");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && iter_reg == '0) |=> (state_reg == ST_DONE))
        else $error("divider did not finish on its last step");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        have_ref_reg |-> (count_reg != '0))
        else $error("sample count is zero with a reference crossing");

endmodule : zero_crossing_period_finder_core
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - zero_crossing_period_finder_core regression
// Drives signed samples through the valid/ready input channel and predicts
// every period from a model of the crossing tracker, including interpolated
// fractions, the first-crossing reference and count saturation. Both sides
// idle at random, and a long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import zcpf_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int FRAC_BITS   = FRAC_BITS_DEF;
    localparam int COUNT_BITS  = COUNT_BITS_DEF;

    localparam longint PERIOD_MAX     = 64'h0000_0000_FFFF_FFFF;
    localparam int     SETTLE_CYCLES  = 2 * (FRAC_BITS + 2) + 4;
    localparam int     RX_HOLD_CYCLES = 400;
    localparam int     RANDOM_ITEMS   = 500;
    localparam int     MAX_REPORTS    = 10;
    localparam int     CYCLE_LIMIT    = 1_500_000;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                saturated;
    } period_result_t;

    // ------------------------------------------------------------------------
    // Crossing tracker model and expected-period store
    // ------------------------------------------------------------------------
    class period_scoreboard;
        logic signed [SAMPLE_BITS-1:0] prev_sample;
        bit                            have_prev;
        logic        [COUNT_BITS-1:0]  since_cross;
        logic        [FRAC_BITS-1:0]   last_frac;
        bit                            have_ref;
        bit                            count_ovf;
        period_result_t                expected_periods[$];
        int n_samples;
        int n_crossings;
        int n_checked;
        int n_saturated;
        int n_mismatch;

        function new();
            prev_sample = '0;
            have_prev   = 1'b0;
            since_cross = '0;
            last_frac   = '0;
            have_ref    = 1'b0;
            count_ovf   = 1'b0;
            n_samples   = 0;
            n_crossings = 0;
            n_checked   = 0;
            n_saturated = 0;
            n_mismatch  = 0;
        endfunction

        // Advance the tracker by one accepted sample transaction
        function void note_sample(logic signed [SAMPLE_W-1:0] raw);
            logic signed [SAMPLE_BITS-1:0] cur;
            longint                        mag;
            longint                        den;
            longint                        frac;
            longint                        span;
            period_result_t                res;
            cur = raw[SAMPLE_BITS-1:0];
            n_samples++;
            if (!have_prev) begin
                prev_sample = cur;
                have_prev   = 1'b1;
                return;
            end
            if (prev_sample < 0 && cur > 0) begin
                // Interpolated crossing point, truncated
                mag  = -longint'(prev_sample);
                den  = longint'(cur) + mag;
                frac = (mag << FRAC_BITS) / den;
                n_crossings++;
                if (have_ref) begin
                    res.saturated = 1'b0;
                    if (count_ovf) begin
                        res.period    = '1;
                        res.saturated = 1'b1;
                    end else begin
                        span = (longint'(since_cross) << FRAC_BITS) + frac
                             - longint'(last_frac);
                        if (span < 0)
                            span = 0;
                        if (span > PERIOD_MAX) begin
                            span          = PERIOD_MAX;
                            res.saturated = 1'b1;
                        end
                        res.period = PERIOD_W'(span);
                    end
                    if (res.saturated)
                        n_saturated++;
                    expected_periods.insert(expected_periods.size(), res);
                end
                have_ref    = 1'b1;
                last_frac   = FRAC_BITS'(frac);
                since_cross = 1;
                count_ovf   = 1'b0;
            end else if (&since_cross) begin
                count_ovf = 1'b1;
            end else begin
                since_cross++;
            end
            prev_sample = cur;
        endfunction

        // Compare one accepted result transaction with the oldest expectation
        function void check_result(logic [PERIOD_W-1:0] period, logic saturated);
            period_result_t exp_res;
            if (expected_periods.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("ERROR: unexpected result period=%h saturated=%b",
                             period, saturated);
                return;
            end
            exp_res = expected_periods.pop_front();
            n_checked++;
            if (period !== exp_res.period || saturated !== exp_res.saturated) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display({"ERROR: result %0d expected period=%h saturated=%b, ",
                              "got period=%h saturated=%b"},
                             n_checked, exp_res.period, exp_res.saturated,
                             period, saturated);
            end
        endfunction

        function int pending();
            return expected_periods.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample    = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic        [PERIOD_W-1:0] m_period;
    logic                       m_saturated;

    period_scoreboard sb = new();
    bit tx_idle  = 1'b0;
    bit rx_idle  = 1'b0;
    bit hold_req = 1'b0;
    int cycles   = 0;

    zero_crossing_period_finder_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_period    (m_period),
        .m_saturated (m_saturated)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d periods outstanding",
                     cycles, sb.pending());
            $display("zero_crossing_period_finder_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 80)
            return $urandom_range(3, 1);
        else if (r < 95)
            return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    function automatic int run_len();
        if ($urandom_range(99, 0) < 85)
            return $urandom_range(6, 1);
        return $urandom_range(40, 7);
    endfunction

    // Strictly negative value, biased toward small magnitudes now and then
    function automatic shortint neg_value();
        if ($urandom_range(3, 0) == 0)
            return shortint'(-int'($urandom_range(16, 1)));
        return shortint'(-int'($urandom_range(32768, 1)));
    endfunction

    function automatic shortint pos_value();
        if ($urandom_range(3, 0) == 0)
            return shortint'($urandom_range(16, 1));
        return shortint'($urandom_range(32767, 1));
    endfunction

    // Offer one sample and hold it until the transaction completes
    task automatic send_sample(input shortint value);
        s_valid  <= 1'b1;
        s_sample <= value;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_sample(value);
    endtask

    task automatic idle_for(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_paced(input shortint value);
        send_sample(value);
        if (tx_idle && $urandom_range(2, 0) == 0)
            idle_for(pick_gap());
    endtask

    // Stop offering until every expected period has arrived, then settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stalls plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result(m_period, m_saturated);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = RX_HOLD_CYCLES;
            end else if (stall_left == 0 && rx_idle && $urandom_range(3, 0) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    shortint directed_seq[$] = '{
        32767,          // first sample, stored only
        -32768,         // falling, no crossing
        32767,          // first crossing: reference, no result
        -1, 1,          // smallest magnitudes
        -32768, 1,      // fraction close to one
        -1, 32767,      // fraction close to zero
        0, 5,           // zero never crosses
        -5, 0, 5,       // zero between signs breaks the crossing
        -7, -3, 32767,  // negative run then crossing
        -32768, 32767,
        -100, 100
    };

    initial begin : stimulus
        int n;
        int len;
        int kind;
        int seg;
        int rnd_start;

        // Reset
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed edge cases, no idling
        foreach (directed_seq[i])
            send_sample(directed_seq[i]);
        drain();

        rx_idle = 1'b1;

        // Receiver holds off while crossings keep coming
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        repeat (30) begin
            send_sample(neg_value());
            send_sample(pos_value());
        end
        drain();

        // Random waveforms: mostly clean crossings, some noise and breaks
        seg       = 0;
        rnd_start = sb.n_samples;
        while (sb.n_samples - rnd_start < RANDOM_ITEMS) begin
            if (seg % 40 == 0) begin
                tx_idle = ($urandom_range(3, 0) != 0);
                rx_idle = ($urandom_range(3, 0) != 0);
            end
            seg++;
            kind = $urandom_range(9, 0);
            case (kind)
                7: begin
                    n = $urandom_range(6, 1);
                    repeat (n) send_paced(shortint'($urandom));
                end
                8: begin
                    send_paced(neg_value());
                    send_paced(16'sd0);
                    send_paced(pos_value());
                end
                9: begin
                    send_paced(shortint'(-int'($urandom_range(4, 1))));
                    send_paced(shortint'($urandom_range(4, 1)));
                end
                default: begin
                    len = run_len();
                    repeat (len) send_paced(neg_value());
                    len = run_len();
                    repeat (len) begin
                        if ($urandom_range(15, 0) == 0)
                            send_paced(16'sd0);
                        else
                            send_paced(pos_value());
                    end
                end
            endcase
        end
        drain();

        $display("%0d samples sent, %0d crossings seen, %0d periods checked (%0d saturated)",
                 sb.n_samples, sb.n_crossings, sb.n_checked, sb.n_saturated);
        $display("%0d mismatches, %0d cycles", sb.n_mismatch, cycles);
        if (sb.n_mismatch == 0 && sb.pending() == 0) begin
            $display("zero_crossing_period_finder_core regression: pass");
        end else begin
            $display("zero_crossing_period_finder_core regression: fail");
        end
        $finish;
    end

endmodule
